>>> src/efc_pkg.sv
// Shared types, constants and pointer helpers for the word FIFO Ethernet controller.
// No dependencies; imported by the core module and the testbench.
`timescale 1ns / 1ps
package efc_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int TX_DELAY   = 512;
  localparam int RX_DELAY   = 31;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int TXT_W = $clog2(TX_DELAY + 1);
  localparam int RXT_W = $clog2(RX_DELAY + 1);

  localparam logic [CNT_W-1:0] DEPTH_C      = CNT_W'(FIFO_DEPTH);
  localparam logic [TXT_W-1:0] TX_DELAY_C   = TXT_W'(TX_DELAY);
  localparam logic [RXT_W-1:0] RX_DELAY_C   = RXT_W'(RX_DELAY);
  localparam logic [15:0]      STATUS_WORD  = 16'hFFFF;
  localparam logic [15:0]      BRANCH_BIT   = 16'h0004;
  localparam logic [7:0]       SERIAL_HIGH  = 8'hFF;
  localparam logic [7:0]       STATION_RST  = 8'd100;

  typedef enum logic [3:0] {
    K_TICK        = 4'd0,
    K_START       = 4'd1,
    K_PEEK        = 4'd2,
    K_POP         = 4'd3,
    K_STATUS      = 4'd4,
    K_WRITE       = 4'd5,
    K_OUTSTART    = 4'd6,
    K_END         = 4'd7,
    K_INSTART     = 4'd8,
    K_WAIT        = 4'd9,
    K_BRANCH      = 4'd10,
    K_COUNTBRANCH = 4'd11,
    K_CMDREAD     = 4'd12,
    K_SERIAL      = 4'd13,
    K_STEPBEGIN   = 4'd14,
    K_BLOCK       = 4'd15
  } kind_e;

  typedef enum logic [1:0] {
    RS_OFF       = 2'd0,
    RS_WAITING   = 2'd1,
    RS_RECEIVING = 2'd2,
    RS_DONE      = 2'd3
  } rstate_e;

  // Flags that every result beat of one step carries.
  typedef struct packed {
    logic wake;
    logic rxon;
    logic clr;
    logic err;
    logic send;
  } res_flags_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if ({1'b0, p} == (PTR_W+1)'(FIFO_DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(n);
    if (s >= (PTR_W+1)'(FIFO_DEPTH)) s = s - (PTR_W+1)'(FIFO_DEPTH);
    return s[PTR_W-1:0];
  endfunction

endpackage

>>> src/efc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module efc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> src/ethernet_word_fifo_controller_core.sv
// Top level of the word FIFO Ethernet controller: control state, step sequencer,
// output register and APB register. Depends on efc_pkg and efc_ram.
`timescale 1ns / 1ps
// Each microcode function is accepted only in the idle state; peek and pop of a nonempty
// FIFO add a FIFO memory read (ST_RDWAIT) before the result beat. A timer tick that drains
// the transmit FIFO produces one beat per stored word, up to 16 for a full FIFO; for each
// word the sequencer issues the read (ST_DR_ADDR), then moves the data to the output
// register (ST_DR_DATA), waiting there while the output side is stalled. A new item is
// taken while the last result beat waits in the output register, provided the output
// side is not stalled at that edge.
module ethernet_word_fifo_controller_core
  import efc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  kind_i,
  input  logic [15:0] bus_word_i,
  input  logic        rx_frame_present_i,
  input  logic        rx_word_valid_i,
  input  logic [15:0] rx_word_i,
  input  logic        rx_more_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        wakeup_o,
  output logic        tx_valid_o,
  output logic [15:0] tx_word_o,
  output logic        tx_send_o,
  output logic        rx_enable_o,
  output logic        rx_clear_o,
  output logic        error_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_DR_ADDR,
    ST_DR_DATA
  } seq_e;

  seq_e state_q, state_d;

  logic [PTR_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0] wc_q, wc_d;
  logic [1:0]       cmd_q, cmd_d;
  logic             obusy_q, obusy_d, ibusy_q, ibusy_d, igone_q, igone_d;
  rstate_e          rs_q, rs_d;
  logic             wake_q, wake_d, cwait_q, cwait_d, eot_q, eot_d, rxon_q, rxon_d;
  logic [TXT_W-1:0] txt_q, txt_d;
  logic             txa_q, txa_d;
  logic [RXT_W-1:0] rxt_q, rxt_d;
  logic             rxa_q, rxa_d;
  logic [7:0]       station_q;

  // Step decode results.
  logic             clr, err, send, drain, push, mem_rd;
  logic [PTR_W-1:0] push_addr;
  logic [15:0]      push_data, rd;
  logic             fire_tx, fire_rx, rx_active, none_left;
  logic [TXT_W-1:0] txt_dec;
  logic [RXT_W-1:0] rxt_dec;
  res_flags_t       flags;

  // Per-step sequencer registers.
  res_flags_t       flags_q;
  logic [PTR_W-1:0] dptr_q;
  logic [CNT_W-1:0] dleft_q;
  logic             pend_we_q;
  logic [PTR_W-1:0] pend_addr_q;
  logic [15:0]      pend_data_q;

  // Output register.
  logic        out_vld_q;
  logic [15:0] o_rd_q, o_txw_q;
  logic        o_txv_q, o_last_q;
  res_flags_t  o_flags_q;

  logic        out_free, accept;
  logic        ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;
  logic        cfg_we;
  kind_e       kind;

  assign kind     = kind_e'(kind_i);
  assign out_free = !out_vld_q || !out_stall_i;
  assign accept   = in_valid_i && state_q == ST_IDLE && out_free;
  assign in_stall_o = !(state_q == ST_IDLE && out_free);

  // Next control state for one accepted item.
  always_comb begin
    rp_d = rp_q; wc_d = wc_q; cmd_d = cmd_q; obusy_d = obusy_q; ibusy_d = ibusy_q;
    igone_d = igone_q; rs_d = rs_q; wake_d = wake_q; cwait_d = cwait_q; eot_d = eot_q;
    rxon_d = rxon_q; txt_d = txt_q; txa_d = txa_q; rxt_d = rxt_q; rxa_d = rxa_q;
    clr = 1'b0; err = 1'b0; send = 1'b0; drain = 1'b0; push = 1'b0; mem_rd = 1'b0;
    push_addr = '0; push_data = bus_word_i; rd = '0;
    fire_tx = 1'b0; fire_rx = 1'b0; rx_active = 1'b0; none_left = 1'b0;
    txt_dec = (txt_q != '0) ? txt_q - TXT_W'(1) : txt_q;
    rxt_dec = (rxt_q != '0) ? rxt_q - RXT_W'(1) : rxt_q;
    case (kind)
      K_TICK: begin
        if (txa_q) begin
          txt_d   = txt_dec;
          fire_tx = (txt_dec == '0);
        end
        if (rxa_q) begin
          rxt_d   = rxt_dec;
          fire_rx = (rxt_dec == '0);
        end
        if (fire_tx) begin
          txa_d = 1'b0;
          if (obusy_q) begin
            drain  = (wc_q != '0);
            rp_d   = '0;
            wc_d   = '0;
            wake_d = 1'b1;
            if (eot_q) begin
              obusy_d = 1'b0;
              send    = 1'b1;
            end
          end
        end
        if (fire_rx) begin
          case (rs_q)
            RS_WAITING: begin
              if (rx_frame_present_i) rs_d = RS_RECEIVING;
              rx_active = 1'b1;
            end
            RS_RECEIVING: begin
              rx_active = 1'b1;
              if (wc_d < DEPTH_C) begin
                if (rx_word_valid_i) begin
                  push      = 1'b1;
                  push_addr = ptr_add(rp_d, wc_d);
                  push_data = rx_word_i;
                  wc_d      = wc_d + CNT_W'(1);
                end
                none_left = rx_word_valid_i ? !rx_more_i : 1'b1;
                if (none_left) begin
                  igone_d   = 1'b1;
                  clr       = 1'b1;
                  rs_d      = RS_DONE;
                  wake_d    = 1'b1;
                  rx_active = 1'b0;
                end
                if (wc_d >= CNT_W'(2)) wake_d = 1'b1;
              end
            end
            RS_OFF: clr = 1'b1;
            default: ;
          endcase
          rxt_d = rx_active ? RX_DELAY_C : '0;
          rxa_d = rx_active;
        end
      end
      K_START: begin
        cmd_d  = bus_word_i[1:0];
        wake_d = 1'b1;
      end
      K_PEEK: mem_rd = (wc_q != '0);
      K_POP: begin
        if (wc_q != '0) begin
          mem_rd = 1'b1;
          rp_d   = ptr_inc(rp_q);
          wc_d   = wc_q - CNT_W'(1);
          if (wc_d < CNT_W'(2)) begin
            if (igone_q) begin
              ibusy_d = 1'b0;
              wake_d  = 1'b1;
            end else begin
              wake_d = 1'b0;
            end
          end
        end
      end
      K_STATUS: begin
        rd = STATUS_WORD;
        cmd_d = '0; obusy_d = 1'b0; ibusy_d = 1'b0; igone_d = 1'b0; rs_d = RS_OFF;
        rxon_d = 1'b0; clr = 1'b1; rp_d = '0; wc_d = '0; wake_d = 1'b0;
      end
      K_WRITE: begin
        if (wc_q >= DEPTH_C) begin
          err = 1'b1;
        end else begin
          push      = 1'b1;
          push_addr = ptr_add(rp_q, wc_q);
          wc_d      = wc_q + CNT_W'(1);
          if (wc_d >= DEPTH_C - CNT_W'(1)) begin
            if (obusy_q) begin
              txt_d = TX_DELAY_C;
              txa_d = 1'b1;
              eot_d = 1'b0;
            end
            wake_d = 1'b0;
          end
        end
      end
      K_OUTSTART: begin
        obusy_d = 1'b1;
        wake_d  = 1'b1;
      end
      K_END: begin
        txt_d  = TX_DELAY_C;
        txa_d  = 1'b1;
        eot_d  = 1'b1;
        wake_d = 1'b0;
      end
      K_INSTART: begin
        if (ibusy_q) clr = 1'b1;
        rxon_d  = 1'b1;
        rs_d    = RS_WAITING;
        ibusy_d = 1'b1;
        wake_d  = 1'b0;
        if (!rxa_q) begin
          rxt_d = RX_DELAY_C;
          rxa_d = 1'b1;
        end
      end
      K_WAIT: cwait_d = 1'b1;
      K_BRANCH: begin
        if (cmd_q != '0 || (!ibusy_q && !obusy_q)) rd = BRANCH_BIT;
      end
      K_COUNTBRANCH: begin
        if (wc_q != '0) rd = BRANCH_BIT;
      end
      K_CMDREAD: rd = {12'd0, cmd_q, 2'b00};
      K_SERIAL: rd = {SERIAL_HIGH, station_q};
      K_STEPBEGIN: begin
        if (cwait_q) begin
          cwait_d = 1'b0;
          wake_d  = 1'b0;
        end
      end
      default: wake_d = 1'b0;
    endcase
    flags.wake = wake_d;
    flags.rxon = rxon_d;
    flags.clr  = clr;
    flags.err  = err;
    flags.send = send;
  end

  // Memory port selection. A receive push that follows a drain waits until the drain
  // has read every old word, since it lands at the start of the emptied FIFO.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = push_addr;
    ram_wdata = push_data;
    ram_re    = 1'b0;
    ram_raddr = rp_q;
    if (accept && push && !drain) begin
      ram_we = 1'b1;
    end
    if (state_q == ST_DR_DATA && out_free && dleft_q == CNT_W'(1) && pend_we_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = pend_data_q;
    end
    if (accept && mem_rd && !drain) begin
      ram_re = 1'b1;
    end
    if (state_q == ST_DR_ADDR) begin
      ram_re    = 1'b1;
      ram_raddr = dptr_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (drain) state_d = ST_DR_ADDR;
          else if (mem_rd) state_d = ST_RDWAIT;
        end
      end
      ST_RDWAIT:  state_d = ST_IDLE;
      ST_DR_ADDR: state_d = ST_DR_DATA;
      ST_DR_DATA: begin
        if (out_free) state_d = (dleft_q == CNT_W'(1)) ? ST_IDLE : ST_DR_ADDR;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  efc_ram #(
    .WIDTH(16),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rp_q <= '0; wc_q <= '0; cmd_q <= '0; obusy_q <= 1'b0; ibusy_q <= 1'b0;
      igone_q <= 1'b0; rs_q <= RS_OFF; wake_q <= 1'b0; cwait_q <= 1'b0; eot_q <= 1'b0;
      rxon_q <= 1'b0; txt_q <= '0; txa_q <= 1'b0; rxt_q <= '0; rxa_q <= 1'b0;
      station_q <= STATION_RST;
      out_vld_q <= 1'b0;
      pend_we_q <= 1'b0;
      dleft_q <= '0;
      flags_q <= '0; dptr_q <= '0; pend_addr_q <= '0; pend_data_q <= '0;
      o_rd_q <= '0; o_txw_q <= '0; o_txv_q <= 1'b0; o_last_q <= 1'b0; o_flags_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) station_q <= pwdata[7:0];
      if (accept) begin
        rp_q <= rp_d; wc_q <= wc_d; cmd_q <= cmd_d; obusy_q <= obusy_d;
        ibusy_q <= ibusy_d; igone_q <= igone_d; rs_q <= rs_d; wake_q <= wake_d;
        cwait_q <= cwait_d; eot_q <= eot_d; rxon_q <= rxon_d; txt_q <= txt_d;
        txa_q <= txa_d; rxt_q <= rxt_d; rxa_q <= rxa_d;
        flags_q     <= flags;
        dptr_q      <= rp_q;
        dleft_q     <= wc_q;
        pend_we_q   <= push && drain;
        pend_addr_q <= push_addr;
        pend_data_q <= push_data;
      end
      // Output register: a beat leaves when not stalled, a new one may enter together.
      if (accept && !drain && !mem_rd) begin
        out_vld_q <= 1'b1;
        o_rd_q    <= rd;
        o_txv_q   <= 1'b0;
        o_txw_q   <= '0;
        o_last_q  <= 1'b1;
        o_flags_q <= flags;
      end else if (state_q == ST_RDWAIT) begin
        out_vld_q <= 1'b1;
        o_rd_q    <= ram_rdata;
        o_txv_q   <= 1'b0;
        o_txw_q   <= '0;
        o_last_q  <= 1'b1;
        o_flags_q <= flags_q;
      end else if (state_q == ST_DR_DATA && out_free) begin
        out_vld_q      <= 1'b1;
        o_rd_q         <= '0;
        o_txv_q        <= 1'b1;
        o_txw_q        <= ram_rdata;
        o_last_q       <= (dleft_q == CNT_W'(1));
        o_flags_q      <= {flags_q.wake, flags_q.rxon, flags_q.clr, flags_q.err,
                           flags_q.send && (dleft_q == CNT_W'(1))};
        dptr_q         <= ptr_inc(dptr_q);
        dleft_q        <= dleft_q - CNT_W'(1);
        if (dleft_q == CNT_W'(1)) pend_we_q <= 1'b0;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign read_data_o = o_rd_q;
  assign wakeup_o    = o_flags_q.wake;
  assign tx_valid_o  = o_txv_q;
  assign tx_word_o   = o_txw_q;
  assign tx_send_o   = o_flags_q.send;
  assign rx_enable_o = o_flags_q.rxon;
  assign rx_clear_o  = o_flags_q.clr;
  assign error_o     = o_flags_q.err;
  assign last_o      = o_last_q;

  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {24'd0, station_q};
  assign pready = 1'b1;

  // Items are only taken while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == ST_IDLE)
    else $error("item accepted while a step is in progress");

  // The word count never exceeds the FIFO depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= DEPTH_C)
    else $error("FIFO word count out of range");

  // A drain always has at least one word left to emit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DR_ADDR || state_q == ST_DR_DATA) |-> dleft_q != '0)
    else $error("drain running with no words left");

  // A beat that flags a packet send carries the last mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && o_flags_q.send) |-> o_last_q)
    else $error("packet send flagged on a non-final beat");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the word FIFO Ethernet controller core.
// Drives microcode functions and timer ticks, predicts every result beat, and
// depends only on efc_pkg and the core's RTL.
`timescale 1ns / 1ps
module tb;
  import efc_pkg::*;

  localparam logic [2:0] STATION_ADDR = 3'd0;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [15:0] rd;
    logic        wake;
    logic        txv;
    logic [15:0] txw;
    logic        send;
    logic        rxen;
    logic        clr;
    logic        err;
    logic        last;
  } beat_t;

  typedef struct {
    kind_e       k;
    logic [15:0] bus;
    logic        chk;
    logic [15:0] rd;
  } row_t;

  logic clk, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [3:0] kind_i;
  logic [15:0] bus_word_i, rx_word_i;
  logic rx_frame_present_i, rx_word_valid_i, rx_more_i;
  logic [15:0] read_data_o, tx_word_o;
  logic wakeup_o, tx_valid_o, tx_send_o, rx_enable_o, rx_clear_o, error_o, last_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  ethernet_word_fifo_controller_core DUT (.clk_i(clk), .*);

  // Predictor state of the controller.
  logic [15:0] fifo_mem [FIFO_DEPTH];
  logic [3:0]  rd_ptr;
  int          wcount;
  logic [1:0]  io_cmd;
  logic        tx_busy, in_busy, in_gone, rx_on, wake, cd_wait, eot, clr;
  rstate_e     rstate;
  logic [15:0] status;
  int          tx_left, rx_left;
  logic        tx_arm, rx_arm;
  logic [7:0]  station;

  beat_t expected_beats[$];
  int    errors = 0;
  int    n_items = 0, n_beats = 0, n_tx_words = 0, n_sends = 0, n_full_writes = 0;
  bit    quiet = 0, hold_req = 0;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic void link_state_reset();
    status   = 16'hFFFF;
    io_cmd   = '0;
    tx_busy  = 0;
    in_busy  = 0;
    in_gone  = 0;
    rstate   = RS_OFF;
    rx_on    = 0;
    clr      = 1;
    rd_ptr   = '0;
    wcount   = 0;
    wake     = 0;
  endfunction

  function automatic void push_word(logic [15:0] w);
    fifo_mem[4'(rd_ptr + wcount)] = w;
    wcount++;
  endfunction

  function automatic logic [15:0] read_word(bit remove);
    logic [15:0] w;
    if (wcount == 0) return 16'h0000;
    w = fifo_mem[rd_ptr];
    if (remove) begin
      rd_ptr++;
      wcount--;
      if (wcount < 2) begin
        if (in_gone) begin
          in_busy = 0;
          wake = 1;
        end else begin
          wake = 0;
        end
      end
    end
    return w;
  endfunction

  // Works out the result beats of one accepted item.
  function automatic void predict_step(kind_e k, logic [15:0] bus, logic fp, logic wv,
                             logic [15:0] w, logic more, logic chk, logic [15:0] chk_rd);
    beat_t b;
    beat_t bl[$];
    logic [15:0] rd;
    logic err, send, fire_tx, fire_rx, active, none_left;
    rd = 0; err = 0; send = 0; fire_tx = 0; fire_rx = 0;
    clr = 0;
    case (k)
      K_TICK: begin
        if (tx_arm) begin
          if (tx_left > 0) tx_left--;
          fire_tx = (tx_left == 0);
        end
        if (rx_arm) begin
          if (rx_left > 0) rx_left--;
          fire_rx = (rx_left == 0);
        end
        if (fire_tx) begin
          tx_arm = 0;
          if (tx_busy) begin
            while (wcount > 0) begin
              b = '{default: 0};
              b.txv = 1;
              b.txw = fifo_mem[rd_ptr];
              bl.push_back(b);
              rd_ptr++;
              wcount--;
            end
            rd_ptr = '0;
            wcount = 0;
            wake = 1;
            if (eot) begin
              tx_busy = 0;
              send = 1;
            end
          end
        end
        if (fire_rx) begin
          active = 0;
          case (rstate)
            RS_WAITING: begin
              if (fp) rstate = RS_RECEIVING;
              active = 1;
            end
            RS_RECEIVING: begin
              active = 1;
              // A full FIFO takes no word but keeps the receiver going.
              if (wcount < FIFO_DEPTH) begin
                if (wv) push_word(w);
                none_left = wv ? !more : 1'b1;
                if (none_left) begin
                  in_gone = 1;
                  clr = 1;
                  rstate = RS_DONE;
                  wake = 1;
                  active = 0;
                end
                if (wcount >= 2) wake = 1;
              end
            end
            RS_OFF: clr = 1;
            default: ;
          endcase
          rx_left = active ? RX_DELAY : 0;
          rx_arm = active;
        end
      end
      K_START: begin
        io_cmd = bus[1:0];
        wake = 1;
      end
      K_PEEK: rd = read_word(0);
      K_POP: rd = read_word(1);
      K_STATUS: begin
        rd = status;
        link_state_reset();
      end
      K_WRITE: begin
        if (wcount >= FIFO_DEPTH) begin
          err = 1;
          n_full_writes++;
        end else begin
          push_word(bus);
          if (wcount >= FIFO_DEPTH - 1) begin
            if (tx_busy) begin
              tx_left = TX_DELAY;
              tx_arm = 1;
              eot = 0;
            end
            wake = 0;
          end
        end
      end
      K_OUTSTART: begin
        tx_busy = 1;
        wake = 1;
      end
      K_END: begin
        tx_left = TX_DELAY;
        tx_arm = 1;
        eot = 1;
        wake = 0;
      end
      K_INSTART: begin
        if (in_busy) clr = 1;
        rx_on = 1;
        rstate = RS_WAITING;
        in_busy = 1;
        wake = 0;
        if (!rx_arm) begin
          rx_left = RX_DELAY;
          rx_arm = 1;
        end
      end
      K_WAIT: cd_wait = 1;
      K_BRANCH: if (io_cmd != 0 || (!in_busy && !tx_busy)) rd = 16'h0004;
      K_COUNTBRANCH: if (wcount != 0) rd = 16'h0004;
      K_CMDREAD: rd = {12'h000, io_cmd, 2'b00};
      K_SERIAL: rd = {8'hFF, station};
      K_STEPBEGIN: if (cd_wait) begin
        cd_wait = 0;
        wake = 0;
      end
      default: wake = 0;
    endcase
    if (bl.size() == 0) begin
      b = '{default: 0};
      b.rd = chk ? chk_rd : rd;
      bl.push_back(b);
    end
    foreach (bl[i]) begin
      bl[i].wake = wake;
      bl[i].rxen = rx_on;
      bl[i].clr  = clr;
      bl[i].err  = err;
      bl[i].last = (i == bl.size() - 1);
      bl[i].send = (i == bl.size() - 1) && send;
      expected_beats.push_back(bl[i]);
    end
  endfunction

  task automatic send_item(kind_e k, logic [15:0] bus, logic chk = 0, logic [15:0] chk_rd = 0);
    int gap;
    logic fp, wv, more;
    logic [15:0] w;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i = 0;
      repeat (gap) @(negedge clk);
    end
    fp = $urandom_range(0, 3) != 0;
    wv = $urandom_range(0, 4) != 0;
    more = $urandom_range(0, 5) != 0;
    w = $urandom_range(0, 16'hFFFF);
    in_valid_i = 1;
    kind_i = k;
    bus_word_i = bus;
    rx_frame_present_i = fp;
    rx_word_valid_i = wv;
    rx_word_i = w;
    rx_more_i = more;
    do @(posedge clk); while (in_stall_o);
    predict_step(k, bus, fp, wv, w, more, chk, chk_rd);
    n_items++;
    @(negedge clk);
    in_valid_i = 0;
  endtask

  task automatic drain_and_settle();
    wait (expected_beats.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_station(logic [7:0] v);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = STATION_ADDR; pwdata = {24'h0, v};
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    station = v;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(K_TICK, $urandom_range(0, 16'hFFFF));
  endtask

  task automatic random_item();
    kind_e k;
    k = kind_e'($urandom_range(0, 15));
    if ($urandom_range(0, 2) == 0) k = K_TICK;
    send_item(k, $urandom_range(0, 16'hFFFF));
  endtask

  task automatic transmit_packet(bit with_end);
    send_item(K_OUTSTART, $urandom_range(0, 16'hFFFF));
    repeat (FIFO_DEPTH - 1) send_item(K_WRITE, $urandom_range(0, 16'hFFFF));
    if (with_end) send_item(K_END, $urandom_range(0, 16'hFFFF));
    ticks(TX_DELAY);
  endtask

  // Output side: random stall per beat, plus one long hold-off on request.
  initial begin
    int w;
    out_stall_i = 1;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_stall_i = 1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      w = draw_gap();
      if (w > 0) begin
        out_stall_i = 1;
        repeat (w) @(negedge clk);
      end
      out_stall_i = 0;
      do @(posedge clk); while (!out_valid_o);
      @(negedge clk);
    end
  end

  task automatic check_field(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $error("%s expected %h got %h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        e = expected_beats.pop_front();
        n_beats++;
        if (e.txv) n_tx_words++;
        if (e.send) n_sends++;
        check_field("read_data", e.rd, read_data_o);
        check_field("wakeup", e.wake, wakeup_o);
        check_field("tx_valid", e.txv, tx_valid_o);
        check_field("tx_word", e.txw, tx_word_o);
        check_field("tx_send", e.send, tx_send_o);
        check_field("rx_enable", e.rxen, rx_enable_o);
        check_field("rx_clear", e.clr, rx_clear_o);
        check_field("error", e.err, error_o);
        check_field("last", e.last, last_o);
      end
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    row_t rows[$];
    int start_items;
    in_valid_i = 0; kind_i = K_TICK; bus_word_i = 0; rx_word_i = 0;
    rx_frame_present_i = 0; rx_word_valid_i = 0; rx_more_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    station = STATION_RST; cd_wait = 0; eot = 0;
    tx_left = 0; tx_arm = 0; rx_left = 0; rx_arm = 0;
    link_state_reset();
    clr = 0;
    rst_ni = 0;
    repeat (6) @(negedge clk);
    rst_ni = 1;

    rows = '{
      '{K_STATUS, 16'h0000, 1, 16'hFFFF}, '{K_SERIAL, 16'hFFFF, 1, 16'hFF64},
      '{K_PEEK, 16'h0000, 1, 16'h0000}, '{K_POP, 16'h0000, 1, 16'h0000},
      '{K_COUNTBRANCH, 16'h0, 1, 16'h0000}, '{K_BRANCH, 16'h0, 1, 16'h0004},
      '{K_START, 16'hFFFF, 0, 0}, '{K_CMDREAD, 16'h0, 1, 16'h000C},
      '{K_START, 16'h0000, 0, 0}, '{K_WRITE, 16'h0000, 0, 0},
      '{K_WRITE, 16'hFFFF, 0, 0}, '{K_COUNTBRANCH, 16'h0, 1, 16'h0004},
      '{K_PEEK, 16'h0, 0, 0}, '{K_POP, 16'h0, 0, 0}, '{K_POP, 16'h0, 1, 16'hFFFF},
      '{K_WAIT, 16'h0, 0, 0}, '{K_STEPBEGIN, 16'h0, 0, 0}, '{K_BLOCK, 16'h0, 0, 0},
      '{K_OUTSTART, 16'h0, 0, 0}, '{K_BRANCH, 16'h0, 0, 0}, '{K_INSTART, 16'h0, 0, 0},
      '{K_INSTART, 16'h0, 0, 0}, '{K_TICK, 16'h0, 0, 0}, '{K_END, 16'h0, 0, 0},
      '{K_STATUS, 16'h0, 1, 16'hFFFF}
    };
    foreach (rows[i]) send_item(rows[i].k, rows[i].bus, rows[i].chk, rows[i].rd);

    drain_and_settle();
    write_station(8'h00);
    send_item(K_SERIAL, 0, 1, 16'hFF00);
    drain_and_settle();
    write_station(8'hFF);
    send_item(K_SERIAL, 0, 1, 16'hFFFF);

    // A packet that first fills the FIFO close to full and is then closed by end.
    transmit_packet(1);

    start_items = n_items;
    while (n_items - start_items < 250) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat (4) random_item();
        4, 5: begin
          send_item(K_INSTART, $urandom_range(0, 16'hFFFF));
          repeat ($urandom_range(40, 120)) begin
            if ($urandom_range(0, 4) == 0) send_item(K_POP, $urandom_range(0, 16'hFFFF));
            else ticks(1);
          end
        end
        6: repeat ($urandom_range(14, 18)) send_item(K_WRITE, $urandom_range(0, 16'hFFFF));
        7: send_item(K_STATUS, $urandom_range(0, 16'hFFFF));
        8: begin
          quiet = 1;
          repeat (10) random_item();
          quiet = 0;
        end
        default: begin
          drain_and_settle();
          write_station($urandom_range(0, 255));
          send_item(K_SERIAL, 0);
        end
      endcase
    end

    // Long output hold-off while items keep coming, then a full pause.
    hold_req = 1;
    repeat (40) send_item(kind_e'($urandom_range(1, 15)), $urandom_range(0, 16'hFFFF));
    wait (expected_beats.size() == 0);
    repeat (20) random_item();

    wait (expected_beats.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d items, %0d result beats, %0d transmit words, %0d sends,",
             n_items, n_beats, n_tx_words, n_sends);
    $display("%0d writes into a full FIFO and several station addresses.", n_full_writes);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
